[rtl/rni_pkg.sv]
// Package for the Roman numeral decoder: letter ranks, letter values and the
// decoder state record with its reset value. No dependencies.
package rni_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned ValueWidth = 14;
   localparam int unsigned RankWidth  = 3;
   localparam int unsigned LetterWidth = 11;

   typedef logic [RankWidth-1:0]   rank_type;
   typedef logic [ValueWidth-1:0]  total_type;
   typedef logic [LetterWidth-1:0] letter_type;

   localparam rank_type   RankI  = 3'd0;
   localparam rank_type   RankV  = 3'd1;
   localparam rank_type   RankX  = 3'd2;
   localparam rank_type   RankL  = 3'd3;
   localparam rank_type   RankC  = 3'd4;
   localparam rank_type   RankD  = 3'd5;
   localparam rank_type   RankM  = 3'd6;
   localparam rank_type   NoRank = 3'd7;

   localparam total_type  TotalMax   = total_type'(16383);
   localparam logic [1:0] RunStart   = 2'd2;
   localparam logic [1:0] RunMax     = 2'd3;
   localparam rank_type   MaxSpan    = 3'd2;

   typedef struct packed {
      logic       pending_flag;
      rank_type   pending_rank;
      logic       run_flag;
      rank_type   run_rank;
      logic [1:0] run_length;
      rank_type   rank_ceiling;
      total_type  running_total;
      logic       error_flag;
   } rni_state_type;

   localparam rni_state_type StateReset = '{
      pending_flag:  1'b0,
      pending_rank:  RankI,
      run_flag:      1'b0,
      run_rank:      RankI,
      run_length:    2'd0,
      rank_ceiling:  NoRank,
      running_total: '0,
      error_flag:    1'b0
   };

   function automatic rank_type rank_of(input logic [CharWidth-1:0] c);
      rank_type r;
      unique case (c)
         8'h49:   r = RankI;
         8'h56:   r = RankV;
         8'h58:   r = RankX;
         8'h4C:   r = RankL;
         8'h43:   r = RankC;
         8'h44:   r = RankD;
         8'h4D:   r = RankM;
         default: r = NoRank;
      endcase
      return r;
   endfunction

   function automatic letter_type letter_value(input rank_type r);
      letter_type v;
      unique case (r)
         RankI:   v = 11'd1;
         RankV:   v = 11'd5;
         RankX:   v = 11'd10;
         RankL:   v = 11'd50;
         RankC:   v = 11'd100;
         RankD:   v = 11'd500;
         RankM:   v = 11'd1000;
         default: v = 11'd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/rni_if.sv]
// Channel interfaces for the Roman numeral decoder: character beats in,
// value beats out. Depends on rni_pkg.
interface rni_req_if import rni_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] char_code;
   logic                 last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface rni_rsp_if import rni_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] value;
   logic                  valid_res;

   modport source (output valid, output value, output valid_res, input ready);
   modport sink   (input valid, input value, input valid_res, output ready);
endinterface

[rtl/roman_numeral_to_integer.sv]
// Roman numeral decoder top level: input register, one-pass token logic and
// result register. Depends on rni_pkg and the channel interfaces in rni_if.sv.
//
//   channel   dir   payload                 beat
//   req_bus   in    char_code, last_char    one character
//   rsp_bus   out   value, valid_res        one decoded numeral
//
// One character per cycle, unless a last character waits on a stalled result;
// a result is offered from the result register once its last character has passed the input register.
// Reset clears the decoder state and both valid flags.
// A stalled result holds; characters keep flowing into the input register and
// only a last character waits for the result register to free up.
module roman_numeral_to_integer
   import rni_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   rni_req_if.sink       req_bus,
   rni_rsp_if.source     rsp_bus
);

   logic                 in_valid_ff;
   logic [CharWidth-1:0] in_char_ff;
   logic                 in_last_ff;
   logic                 advance;

   rni_state_type        state_ff, state_in, step;
   logic                 rsp_valid_ff;
   total_type            rsp_value_ff, rsp_value_in;
   logic                 rsp_ok_ff;

   rank_type             r, t;
   logic [LetterWidth:0] add_one, add_two;
   logic [ValueWidth+1:0] sum;
   total_type            sat_total;

   assign advance       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready) begin
         in_char_ff <= req_bus.char_code;
         in_last_ff <= req_bus.last_char;
      end
   end

   always_comb begin
      step    = state_ff;
      add_one = '0;
      add_two = '0;
      r       = rank_of(in_char_ff);
      t       = state_ff.pending_rank;
      if (!state_ff.error_flag) begin
         priority if (r == NoRank) begin
            step.error_flag = 1'b1;
         end else if (state_ff.pending_flag) begin
            priority if (t < r) begin
               if ((t[0] && r[0]) || (rank_type'(r - t) > MaxSpan)) begin
                  step.error_flag = 1'b1;
               end else begin
                  add_one = {1'b0, letter_value(r) - letter_value(t)};
                  step.rank_ceiling = t;
                  step.pending_flag = 1'b0;
               end
            end else if (t == r) begin
               if (t[0]) begin
                  step.error_flag = 1'b1;
               end else begin
                  step.run_flag     = 1'b1;
                  step.run_rank     = t;
                  step.run_length   = RunStart;
                  step.rank_ceiling = t;
                  step.pending_flag = 1'b0;
               end
            end else begin
               add_one = {1'b0, letter_value(t)};
               if (r >= state_ff.rank_ceiling) begin
                  step.error_flag   = 1'b1;
                  step.pending_flag = 1'b0;
               end else begin
                  step.pending_flag = 1'b1;
                  step.pending_rank = r;
               end
            end
         end else if (state_ff.run_flag) begin
            if (r == state_ff.run_rank) begin
               if (state_ff.run_length >= RunMax) begin
                  step.error_flag = 1'b1;
               end else begin
                  step.run_length = state_ff.run_length + 2'd1;
               end
            end else begin
               add_one = (LetterWidth+1)'(state_ff.run_length)
                       * (LetterWidth+1)'(letter_value(state_ff.run_rank));
               step.run_flag = 1'b0;
               if (r >= state_ff.rank_ceiling) begin
                  step.error_flag = 1'b1;
               end else begin
                  step.pending_flag = 1'b1;
                  step.pending_rank = r;
               end
            end
         end else begin
            if (r >= state_ff.rank_ceiling) begin
               step.error_flag = 1'b1;
            end else begin
               step.pending_flag = 1'b1;
               step.pending_rank = r;
            end
         end
      end
      // closing the numeral flushes a waiting letter or an open run
      if (in_last_ff && !step.error_flag) begin
         if (step.pending_flag) begin
            add_two = {1'b0, letter_value(step.pending_rank)};
         end else if (step.run_flag) begin
            add_two = (LetterWidth+1)'(step.run_length)
                    * (LetterWidth+1)'(letter_value(step.run_rank));
         end
      end
      // both adds are non-negative, so one saturation at the end suffices
      sum = (ValueWidth+2)'(state_ff.running_total) + (ValueWidth+2)'(add_one)
          + (ValueWidth+2)'(add_two);
      sat_total = (sum > (ValueWidth+2)'(TotalMax)) ? TotalMax : sum[ValueWidth-1:0];
      step.running_total = sat_total;
      rsp_value_in = step.error_flag ? '0 : sat_total;
      state_in = in_last_ff ? StateReset : step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (advance && in_last_ff) begin
         rsp_value_ff <= rsp_value_in;
         rsp_ok_ff    <= !step.error_flag;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.value     = rsp_value_ff;
   assign rsp_bus.valid_res = rsp_ok_ff;

endmodule

[rtl/rni_checker.sv]
// Port-level checks for the Roman numeral decoder, bound to its top level.
// Depends on rni_pkg and roman_numeral_to_integer.
module rni_checker
   import rni_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [ValueWidth-1:0] rsp_value,
   input logic                  rsp_valid_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_valid_res))
      else $error("stalled result beat changed");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_value == '0)
      else $error("rejected numeral carries a value");

   a_good_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_value != '0)
      else $error("accepted numeral decoded to zero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind roman_numeral_to_integer rni_checker u_rni_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_value     (rsp_bus.value),
   .rsp_valid_res (rsp_bus.valid_res)
);

[bench/tb.sv]
// Self-checking bench for roman_numeral_to_integer: character beats in, decoded
// values out, with a local decoder model scoring every result.
// Depends on rni_pkg, rni_if.sv and the top level in rtl.
module tb;
   import rni_pkg::*;

   localparam int unsigned RandomItems = 1420;
   localparam int unsigned HoldCycles  = 400;
   localparam int unsigned NumRows     = 11;

   typedef struct packed {
      total_type value;
      logic      ok;
   } decoded_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rni_req_if req_bus ();
   rni_rsp_if rsp_bus ();

   roman_numeral_to_integer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // decoder model state
   logic       held_flag;
   rank_type   held_rank;
   logic       rep_flag;
   rank_type   rep_rank;
   logic [1:0] rep_count;
   rank_type   ceiling;
   total_type  sum;
   logic       bad;

   decoded_type          decoded_q[$];
   decoded_type          head_result;
   logic [CharWidth-1:0] numeral_chars[$];
   int unsigned          mismatches = 0;
   bit                   steady_send = 1'b0;
   bit                   hold_off = 1'b0;

   // directed numerals; a value of -1 leaves the answer to the model,
   // an empty text sends the lone byte instead
   string dir_text [NumRows] = '{"I", "", "", "IIII", "VVX", "IC", "LD", "IXX",
                                 "VX", "DM", "MCMXCIV"};
   logic [CharWidth-1:0] dir_lone [NumRows] = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
                                                8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                                8'h00};
   int dir_value [NumRows] = '{1, 0, 0, 0, 0, 0, 0, 0, -1, -1, -1};
   bit dir_ok    [NumRows] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   string odd_forms [6] = '{"VX", "DM", "LC", "XCVX", "MDMVX", "CDLC"};

   task automatic note_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic rank_type letter_rank(input logic [CharWidth-1:0] c);
      case (c)
         "I":     return RankI;
         "V":     return RankV;
         "X":     return RankX;
         "L":     return RankL;
         "C":     return RankC;
         "D":     return RankD;
         "M":     return RankM;
         default: return NoRank;
      endcase
   endfunction

   function automatic int unsigned worth(input rank_type r);
      case (r)
         RankI:   return 1;
         RankV:   return 5;
         RankX:   return 10;
         RankL:   return 50;
         RankC:   return 100;
         RankD:   return 500;
         RankM:   return 1000;
         default: return 0;
      endcase
   endfunction

   function automatic void clear_decoder();
      held_flag = 1'b0;
      held_rank = RankI;
      rep_flag  = 1'b0;
      rep_rank  = RankI;
      rep_count = 2'd0;
      ceiling   = NoRank;
      sum       = '0;
      bad       = 1'b0;
   endfunction

   function automatic void accumulate(input int unsigned amount);
      int unsigned s;
      s = sum + amount;
      sum = (s > TotalMax) ? TotalMax : total_type'(s);
   endfunction

   function automatic void open_token(input rank_type r);
      if (r >= ceiling) begin
         bad = 1'b1;
      end else begin
         held_flag = 1'b1;
         held_rank = r;
      end
   endfunction

   // advances the model by one character; returns 1 when a numeral completes
   function automatic bit decode_beat(input logic [CharWidth-1:0] c, input bit last,
                                      output decoded_type res);
      rank_type r;
      rank_type t;
      r = letter_rank(c);
      res = '0;
      if (!bad) begin
         if (r == NoRank) begin
            bad = 1'b1;
         end else if (held_flag) begin
            t = held_rank;
            if (t < r) begin
               if ((t[0] && r[0]) || (r - t > MaxSpan)) begin
                  bad = 1'b1;
               end else begin
                  accumulate(worth(r) - worth(t));
                  ceiling = t;
                  held_flag = 1'b0;
               end
            end else if (t == r) begin
               if (t[0]) begin
                  bad = 1'b1;
               end else begin
                  rep_flag  = 1'b1;
                  rep_rank  = t;
                  rep_count = RunStart;
                  ceiling   = t;
                  held_flag = 1'b0;
               end
            end else begin
               accumulate(worth(t));
               held_flag = 1'b0;
               open_token(r);
            end
         end else if (rep_flag) begin
            if (r == rep_rank) begin
               if (rep_count >= RunMax) bad = 1'b1;
               else rep_count++;
            end else begin
               accumulate(rep_count * worth(rep_rank));
               rep_flag = 1'b0;
               open_token(r);
            end
         end else begin
            open_token(r);
         end
      end
      if (!last) return 1'b0;
      if (!bad) begin
         if (held_flag) accumulate(worth(held_rank));
         else if (rep_flag) accumulate(rep_count * worth(rep_rank));
      end
      res.value = bad ? '0 : sum;
      res.ok    = !bad;
      clear_decoder();
      return 1'b1;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 88) return $urandom_range(1, 3);
      if (k < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic string to_roman(input int unsigned n);
      int unsigned amounts [13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
      string marks [13] = '{"M", "CM", "D", "CD", "C", "XC", "L", "XL", "X", "IX",
                            "V", "IV", "I"};
      string s;
      s = "";
      for (int i = 0; i < 13; i++) begin
         while (n >= amounts[i]) begin
            s = {s, marks[i]};
            n -= amounts[i];
         end
      end
      return s;
   endfunction

   function automatic logic [CharWidth-1:0] any_letter();
      string letters;
      letters = "IVXLCDM";
      return letters[$urandom_range(0, 6)];
   endfunction

   function automatic void load_text(input string s);
      numeral_chars.delete();
      for (int k = 0; k < s.len(); k++) numeral_chars.push_back(s[k]);
   endfunction

   function automatic int unsigned pick_value();
      if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3999);
      return $urandom_range(1, 50);
   endfunction

   function automatic void make_numeral();
      int unsigned kind;
      int unsigned pos;
      kind = $urandom_range(0, 99);
      numeral_chars.delete();
      if (kind < 55) begin
         load_text(to_roman(pick_value()));
      end else if (kind < 70) begin
         repeat ($urandom_range(1, 8)) numeral_chars.push_back(any_letter());
      end else if (kind < 82) begin
         load_text(to_roman(pick_value()));
         pos = $urandom_range(0, numeral_chars.size() - 1);
         if ($urandom_range(0, 1) != 0) numeral_chars[pos] = any_letter();
         else numeral_chars[pos] = $urandom_range(0, 255);
      end else if (kind < 90) begin
         repeat ($urandom_range(1, 5)) numeral_chars.push_back($urandom_range(0, 255));
      end else begin
         load_text(odd_forms[$urandom_range(0, 5)]);
      end
   endfunction

   task automatic send_char(input logic [CharWidth-1:0] c, input bit last,
                            input bit typed, input decoded_type typed_res);
      int unsigned idle;
      decoded_type res;
      idle = steady_send ? 0 : idle_len();
      if (idle != 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= c;
      req_bus.last_char <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (decode_beat(c, last, res)) begin
         if (typed) res = typed_res;
         decoded_q.push_back(res);
      end
   endtask

   task automatic send_numeral(input bit typed, input decoded_type typed_res);
      steady_send = ($urandom_range(0, 6) == 0);
      for (int k = 0; k < numeral_chars.size(); k++)
         send_char(numeral_chars[k], k == numeral_chars.size() - 1, typed, typed_res);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned sent;
      bit held;
      bit paused;
      decoded_type typed_res;
      sent   = 0;
      held   = 1'b0;
      paused = 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.char_code <= '0;
      req_bus.last_char <= 1'b0;
      clear_decoder();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NumRows; i++) begin
         if (dir_text[i].len() == 0) begin
            numeral_chars.delete();
            numeral_chars.push_back(dir_lone[i]);
         end else begin
            load_text(dir_text[i]);
         end
         typed_res.value = total_type'(dir_value[i] < 0 ? 0 : dir_value[i]);
         typed_res.ok    = dir_ok[i];
         send_numeral(dir_value[i] >= 0, typed_res);
      end
      drain();

      typed_res = '0;
      while (sent < RandomItems) begin
         if (!held && sent > RandomItems / 3) begin
            hold_off = 1'b1;
            held = 1'b1;
         end
         if (!paused && sent > 2 * RandomItems / 3) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            drain();
            paused = 1'b1;
         end
         make_numeral();
         send_numeral(1'b0, typed_res);
         sent += numeral_chars.size();
      end
      req_bus.valid <= 1'b0;
      drain();
      repeat (10) @(posedge clock);

      if (mismatches == 0 && decoded_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // result side: random stalls, open stretches and one long hold-off
   initial begin
      int unsigned stall;
      int unsigned open_len;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               stall    = 0;
               open_len = $urandom_range(20, 80);
            end else begin
               stall    = idle_len();
               open_len = $urandom_range(1, 4);
            end
            if (stall != 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            repeat (open_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (decoded_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result value=%0d ok=%0b",
                                    rsp_bus.value, rsp_bus.valid_res));
         end else begin
            head_result = decoded_q.pop_front();
            if (rsp_bus.value !== head_result.value)
               note_mismatch($sformatf("value %0d, expected %0d",
                                       rsp_bus.value, head_result.value));
            if (rsp_bus.valid_res !== head_result.ok)
               note_mismatch($sformatf("valid_res %0b, expected %0b",
                                       rsp_bus.valid_res, head_result.ok));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
rtl/rni_pkg.sv
rtl/rni_if.sv
rtl/roman_numeral_to_integer.sv
rtl/rni_checker.sv
bench/tb.sv
